>>> hw/rtl/fpbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpbc_pkg
// Shared types and constants of the frustum point/box cull core: packed
// plane layout, pipeline advance controls and fixed field widths.
// ----------------------------------------------------------------------------
package fpbc_pkg;

  // Planes that have a configuration register
  localparam int PlaneRegs    = 6;
  localparam int CoefBits     = 16;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 64;
  // Q8.8 offset lines up with Q2.14 * Q8.8 products (Q.22)
  localparam int DShift       = 14;

  localparam int DefNumPlanes = 6;
  localparam int DefCoordBits = 16;

  // Register layout: d in [63:48], c in [47:32], b in [31:16], a in [15:0]
  typedef struct packed {
    logic [CoefBits-1:0] d;
    logic [CoefBits-1:0] c;
    logic [CoefBits-1:0] b;
    logic [CoefBits-1:0] a;
  } plane_t;

  // Load enables for the product and sum stages
  typedef struct packed {
    logic s2;
    logic s3;
  } adv_t;

endpackage
`default_nettype wire

>>> hw/rtl/fpbc_plane_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpbc_plane_eval
// Signed distance of one plane over two pipeline stages: vertex select and
// three products, then the sum with the offset and the sign test.
// ----------------------------------------------------------------------------
module fpbc_plane_eval #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk_i,
  input  wire fpbc_pkg::plane_t        plane_i,
  input  wire fpbc_pkg::adv_t          adv_i,
  input  wire                          box_i,
  input  wire logic signed [COORD_BITS-1:0] lo_x_i,
  input  wire logic signed [COORD_BITS-1:0] lo_y_i,
  input  wire logic signed [COORD_BITS-1:0] lo_z_i,
  input  wire logic signed [COORD_BITS-1:0] hi_x_i,
  input  wire logic signed [COORD_BITS-1:0] hi_y_i,
  input  wire logic signed [COORD_BITS-1:0] hi_z_i,
  output logic                         reject_o
);
  import fpbc_pkg::*;

  localparam int ProdW = CoefBits + COORD_BITS;
  localparam int DW    = CoefBits + DShift;
  localparam int SumW  = ((ProdW > DW) ? ProdW : DW) + 2;

  logic signed [CoefBits-1:0]   a_s, b_s, c_s;
  logic signed [COORD_BITS-1:0] vx, vy, vz;
  logic signed [ProdW-1:0]      px_d, py_d, pz_d;
  logic signed [ProdW-1:0]      px_q, py_q, pz_q;
  logic signed [CoefBits-1:0]   d_q;
  logic signed [SumW-1:0]       sum;

  assign a_s = signed'(plane_i.a);
  assign b_s = signed'(plane_i.b);
  assign c_s = signed'(plane_i.c);

  // Pick the positive vertex for boxes, the low corner otherwise
  assign vx = (box_i && !a_s[CoefBits-1]) ? hi_x_i : lo_x_i;
  assign vy = (box_i && !b_s[CoefBits-1]) ? hi_y_i : lo_y_i;
  assign vz = (box_i && !c_s[CoefBits-1]) ? hi_z_i : lo_z_i;

  assign px_d = ProdW'(a_s) * ProdW'(vx);
  assign py_d = ProdW'(b_s) * ProdW'(vy);
  assign pz_d = ProdW'(c_s) * ProdW'(vz);

  // Hold products and offset for the sum stage
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      d_q  <= signed'(plane_i.d);
    end
  end

  // Exact Q.22 distance; negative means outside
  assign sum = SumW'(px_q) + SumW'(py_q) + SumW'(pz_q) + (SumW'(d_q) <<< DShift);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      reject_o <= sum[SumW-1];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/frustum_point_box_cull_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_point_box_cull_core
// Point and axis-aligned box culling against up to six configured planes.
// ----------------------------------------------------------------------------
// Takes one request per clock when the output side is ready and returns one
// result per request once it has passed every stage. The pipeline has an
// input register, a product stage with three 16 x COORD_BITS multipliers per
// plane and a sum/sign stage that doubles as the output register; valid bits
// travel with the data and each stage advances when the stage after it is
// empty or moving, so stalls on the output side back up without loss. For a
// point every plane uses (lo_x, lo_y, lo_z); for a box each plane uses its
// positive vertex, so a box is culled only when it lies wholly outside some
// plane. A distance of exactly zero counts as inside. Planes are written
// through the configuration port (index 0 to 5, 64-bit packed a, b, c, d);
// writes beyond the last plane are dropped, and the port is always ready.
// Write planes only while no request is in flight.
// ----------------------------------------------------------------------------
module frustum_point_box_cull_core #(
  parameter int NUM_PLANES = fpbc_pkg::DefNumPlanes,
  parameter int COORD_BITS = fpbc_pkg::DefCoordBits
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration writes
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [fpbc_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  wire  [fpbc_pkg::CfgDataBits-1:0]    cfg_data_i,
  // request channel
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 op_i,
  input  wire logic signed [COORD_BITS-1:0]   lo_x_i,
  input  wire logic signed [COORD_BITS-1:0]   lo_y_i,
  input  wire logic signed [COORD_BITS-1:0]   lo_z_i,
  input  wire logic signed [COORD_BITS-1:0]   hi_x_i,
  input  wire logic signed [COORD_BITS-1:0]   hi_y_i,
  input  wire logic signed [COORD_BITS-1:0]   hi_z_i,
  // result channel
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic                                visible_o,
  output logic [fpbc_pkg::PlaneRegs-1:0]      reject_mask_o
);
  import fpbc_pkg::*;

  localparam int NumActive = (NUM_PLANES < PlaneRegs) ? NUM_PLANES : PlaneRegs;

  plane_t                       plane_q [NumActive];
  logic                         s1_valid_q, s2_valid_q, s3_valid_q;
  logic                         adv1, adv2, adv3;
  adv_t                         adv;
  logic                         box_q;
  logic signed [COORD_BITS-1:0] lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
  logic [NumActive-1:0]         reject;
  logic [PlaneRegs-1:0]         mask;

  // Plane registers, cleared to all-zero planes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumActive; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NumActive; i++) begin
        if (cfg_idx_i == CfgIdxBits'(i)) begin
          plane_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Advance a stage when the next one is empty or moving
  assign adv3       = !s3_valid_q || out_ready_i;
  assign adv2       = !s2_valid_q || adv3;
  assign adv1       = !s1_valid_q || adv2;
  assign in_ready_o = adv1;
  assign adv.s2     = adv2 && s1_valid_q;
  assign adv.s3     = adv3 && s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      box_q  <= op_i;
      lo_x_q <= lo_x_i;
      lo_y_q <= lo_y_i;
      lo_z_q <= lo_z_i;
      hi_x_q <= hi_x_i;
      hi_y_q <= hi_y_i;
      hi_z_q <= hi_z_i;
    end
  end

  // One distance pipeline per plane
  for (genvar g = 0; g < NumActive; g++) begin : g_plane
    fpbc_plane_eval #(
      .COORD_BITS(COORD_BITS)
    ) u_eval (
      .clk_i   (clk_i),
      .plane_i (plane_q[g]),
      .adv_i   (adv),
      .box_i   (box_q),
      .lo_x_i  (lo_x_q),
      .lo_y_i  (lo_y_q),
      .lo_z_i  (lo_z_q),
      .hi_x_i  (hi_x_q),
      .hi_y_i  (hi_y_q),
      .hi_z_i  (hi_z_q),
      .reject_o(reject[g])
    );
  end

  // Planes without a register never reject
  always_comb begin
    mask = '0;
    for (int i = 0; i < NumActive; i++) begin
      mask[i] = reject[i];
    end
  end

  assign out_valid_o   = s3_valid_q;
  assign reject_mask_o = mask;
  assign visible_o     = ~|mask;

endmodule
`default_nettype wire

>>> hw/rtl/fpbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpbc_checker
// Port-level checks of the cull core, bound to the top level.
// ----------------------------------------------------------------------------
module fpbc_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_o,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire                              visible_o,
  input wire [fpbc_pkg::PlaneRegs-1:0]    reject_mask_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reject_mask_o)
                                    && $stable(visible_o))
    else $error("stalled result changed");

  // Visible exactly when no plane rejects
  a_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (visible_o == (reject_mask_o == '0)))
    else $error("visible disagrees with reject mask");

  // Backpressure only when the output is stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // An accepted request reaches the output when the output side stays ready meanwhile
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind frustum_point_box_cull_core fpbc_checker u_fpbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .visible_o    (visible_o),
  .reject_mask_o(reject_mask_o)
);
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frustum point/box cull core.
// ----------------------------------------------------------------------------
// Writes sets of six clip planes between bursts of point and box queries.
// Each accepted query is run through a local plane-distance predictor, and
// every returned result is checked against the oldest predicted verdict.
// Request and result sides stall at random, except in one calm phase.
// ----------------------------------------------------------------------------
module tb_top;
  import fpbc_pkg::*;

  localparam int COORD_W     = DefCoordBits;
  localparam int IDLE_PCT    = 36;
  localparam int RST_CYCLES  = 12;
  localparam int PIPE_LAT    = 3;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 80;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_BOX   = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_z;
  } query_t;

  typedef struct packed {
    logic                 visible;
    logic [PlaneRegs-1:0] reject_mask;
  } verdict_t;

  // How a plane set is drawn for a random phase
  typedef enum int {PL_EXTREME, PL_RANDOM, PL_AXIS, PL_SPARSE} plane_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx   = '0;
  logic [CfgDataBits-1:0] cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  query_t                 in_q      = '0;
  logic                   out_ready = 1'b0;

  wire                 cfg_ready_o;
  wire                 in_ready_o;
  wire                 out_valid_o;
  wire                 visible_o;
  wire [PlaneRegs-1:0] reject_mask_o;

  plane_t   plane_regs [PlaneRegs];
  query_t   queries_todo [$];
  verdict_t verdicts_due [$];
  int       mismatches   = 0;
  int       stall_cycles = 0;
  bit       steady       = 1'b0;

  frustum_point_box_cull_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .op_i          (in_q.op),
    .lo_x_i        (in_q.lo_x),
    .lo_y_i        (in_q.lo_y),
    .lo_z_i        (in_q.lo_z),
    .hi_x_i        (in_q.hi_x),
    .hi_y_i        (in_q.hi_y),
    .hi_z_i        (in_q.hi_z),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .visible_o     (visible_o),
    .reject_mask_o (reject_mask_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Signed plane distances in Q.22; a box uses its positive vertex per plane
  function automatic verdict_t cull_verdict(input query_t q);
    verdict_t                   v;
    logic signed [COORD_W-1:0]  lo [3];
    logic signed [COORD_W-1:0]  hi [3];
    logic signed [CoefBits-1:0] w [3];
    longint                     dsum;
    int                         i;
    int                         k;
    lo[0] = q.lo_x;
    lo[1] = q.lo_y;
    lo[2] = q.lo_z;
    hi[0] = q.hi_x;
    hi[1] = q.hi_y;
    hi[2] = q.hi_z;
    v.reject_mask = '0;
    for (i = 0; i < PlaneRegs; i++) begin
      w[0] = plane_regs[i].a;
      w[1] = plane_regs[i].b;
      w[2] = plane_regs[i].c;
      dsum = longint'($signed(plane_regs[i].d)) * (longint'(1) << DShift);
      for (k = 0; k < 3; k++) begin
        if (q.op == OP_BOX && w[k] >= 0) begin
          dsum += longint'(w[k]) * longint'(hi[k]);
        end else begin
          dsum += longint'(w[k]) * longint'(lo[k]);
        end
      end
      // zero distance counts as inside
      v.reject_mask[i] = (dsum < 0);
    end
    v.visible = (v.reject_mask == '0);
    return v;
  endfunction

  // Append a query to the pending list
  function automatic void add_query(input query_t q);
    queries_todo = {queries_todo, q};
  endfunction

  function automatic logic [15:0] extreme_word();
    case ($urandom_range(6))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      5: return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom_range(1023) - 512);
      1: return COORD_W'(extreme_word());
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic query_t mk_query(input logic op,
                                      input logic [COORD_W-1:0] lx, ly, lz,
                                      input logic [COORD_W-1:0] hx, hy, hz);
    query_t q;
    q.op   = op;
    q.lo_x = lx;
    q.lo_y = ly;
    q.lo_z = lz;
    q.hi_x = hx;
    q.hi_y = hy;
    q.hi_z = hz;
    return q;
  endfunction

  // Boxes are mostly ordered; about one in five keeps min and max as drawn
  function automatic query_t rand_query();
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    bit                        ordered;
    int                        k;
    ordered = ($urandom_range(4) != 0);
    for (k = 0; k < 3; k++) begin
      u = rand_coord();
      v = rand_coord();
      if (ordered && u > v) begin
        lo[k] = v;
        hi[k] = u;
      end else begin
        lo[k] = u;
        hi[k] = v;
      end
    end
    return mk_query($urandom_range(1) ? OP_BOX : OP_POINT,
                    lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic plane_t plane_for(input plane_mix_e mix, input int i);
    plane_t              p;
    logic [CoefBits-1:0] w;
    p = '0;
    case (mix)
      PL_EXTREME: begin
        p.a = extreme_word();
        p.b = extreme_word();
        p.c = extreme_word();
        p.d = extreme_word();
      end
      PL_RANDOM: p = {$urandom(), $urandom()};
      PL_AXIS: begin
        // even planes bound an axis from below, odd ones from above
        w = (i % 2 == 0) ? 16'h4000 : 16'hC000;
        case (i / 2)
          0: p.a = w;
          1: p.b = w;
          default: p.c = w;
        endcase
        p.d = CoefBits'($urandom_range(16'h4000));
      end
      default: begin
        // leave about half the planes all zero
        if ($urandom_range(1) != 0) p = {$urandom(), $urandom()};
      end
    endcase
    return p;
  endfunction

  // Hold the write until taken; the caller drops cfg_valid after the last one
  task automatic write_plane(input logic [CfgIdxBits-1:0] idx,
                             input logic [CfgDataBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < PlaneRegs) plane_regs[idx] = val;
  endtask

  // Write all planes, then poke the unused indexes, which must be dropped
  task automatic load_planes(input plane_t set [PlaneRegs]);
    int i;
    for (i = 0; i < PlaneRegs; i++) write_plane(CfgIdxBits'(i), set[i]);
    for (i = PlaneRegs; i < (1 << CfgIdxBits); i++) begin
      write_plane(CfgIdxBits'(i), '1);
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for all requests to go in and all results to come back
  task automatic settle();
    do @(posedge clk_i);
    while (queries_todo.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  // Request driver: predict on acceptance, then advance or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) verdicts_due = {verdicts_due, cull_verdict(in_q)};
      if (!in_valid || in_ready_o) begin
        if (queries_todo.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_q     <= queries_todo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, stall at random
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result with no request outstanding: visible %0b, reject_mask %b",
                 visible_o, reject_mask_o);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (visible_o !== want.visible) begin
            $error("visible: expected %0b, got %0b", want.visible, visible_o);
            mismatches++;
          end
          if (reject_mask_o !== want.reject_mask) begin
            $error("reject_mask: expected %b, got %b", want.reject_mask, reject_mask_o);
            mismatches++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Count cycles in which no channel moves anything
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= QUIET_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    plane_t set [PlaneRegs];
    int     ph;
    int     i;
    for (i = 0; i < PlaneRegs; i++) plane_regs[i] = '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Planes are all zero after reset: nothing may be rejected
    add_query(mk_query(OP_POINT, 16'h8000, 16'h8000, 16'h8000,
                       16'h7FFF, 16'h7FFF, 16'h7FFF));
    add_query(mk_query(OP_BOX, 16'h8000, 16'h8000, 16'h8000,
                       16'h7FFF, 16'h7FFF, 16'h7FFF));
    add_query(mk_query(OP_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                       16'h8000, 16'h8000, 16'h8000));
    settle();

    // Hand-built planes, packed as {d, c, b, a}
    set[0] = {16'h0000, 16'h0000, 16'h0000, 16'h4000};  // x >= 0
    set[1] = {16'h1000, 16'h0000, 16'h0000, 16'hC000};  // x <= 16
    set[2] = {16'h0000, 16'h0000, 16'h7FFF, 16'h0000};  // y >= 0, top coefficient
    set[3] = {16'h7FFF, 16'h0000, 16'h8000, 16'h0000};  // -2y + 128 >= 0
    set[4] = {16'hF000, 16'h4000, 16'h0000, 16'h0000};  // z >= 16
    set[5] = {16'h7FFF, 16'h8000, 16'h8000, 16'h8000};  // -2(x+y+z) + 128 >= 0
    load_planes(set);

    // points on three planes at once (zero distance), just outside, extremes
    add_query(mk_query(OP_POINT, 16'h0000, 16'h0000, 16'h1000,
                       16'h0000, 16'h0000, 16'h0000));
    add_query(mk_query(OP_POINT, 16'hFFFF, 16'h0000, 16'h1000,
                       16'h0000, 16'h0000, 16'h0000));
    add_query(mk_query(OP_POINT, 16'h0000, 16'h0000, 16'h0FFF,
                       16'h0000, 16'h0000, 16'h0000));
    add_query(mk_query(OP_POINT, 16'h8000, 16'h8000, 16'h8000,
                       16'h7FFF, 16'h7FFF, 16'h7FFF));
    add_query(mk_query(OP_POINT, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                       16'h8000, 16'h8000, 16'h8000));
    // max corner is ignored for a point
    add_query(mk_query(OP_POINT, 16'h0100, 16'h0100, 16'h1100,
                       16'h8000, 16'h8000, 16'h8000));
    // boxes: inside, straddling x = 0, wholly below x = 0
    add_query(mk_query(OP_BOX, 16'h0100, 16'h0100, 16'h1100,
                       16'h0200, 16'h0200, 16'h1200));
    add_query(mk_query(OP_BOX, 16'hFF00, 16'h0100, 16'h1100,
                       16'h0100, 16'h0200, 16'h1200));
    add_query(mk_query(OP_BOX, 16'h8000, 16'h0100, 16'h1100,
                       16'hFF00, 16'h0200, 16'h1200));
    // inverted boxes are taken as given
    add_query(mk_query(OP_BOX, 16'h0200, 16'h0200, 16'h1200,
                       16'h0100, 16'h0100, 16'h1100));
    add_query(mk_query(OP_BOX, 16'h0100, 16'h0100, 16'h1100,
                       16'hFF00, 16'hFF00, 16'hFF00));
    add_query(mk_query(OP_BOX, 16'h8000, 16'h8000, 16'h8000,
                       16'h7FFF, 16'h7FFF, 16'h7FFF));
    add_query(mk_query(OP_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                       16'h8000, 16'h8000, 16'h8000));
    // degenerate box sitting on the zero-distance point
    add_query(mk_query(OP_BOX, 16'h0000, 16'h0000, 16'h1000,
                       16'h0000, 16'h0000, 16'h1000));
    settle();

    // Random phases, each with a fresh plane set; the axis-box phase runs calm
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      for (i = 0; i < PlaneRegs; i++) set[i] = plane_for(plane_mix_e'(ph % 4), i);
      load_planes(set);
      steady = (plane_mix_e'(ph % 4) == PL_AXIS);
      repeat (PHASE_ITEMS) add_query(rand_query());
      settle();
    end

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
